/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each helper takes a label, the clock,
// the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

/* rtl/core/hlp_pkg.sv */
package hlp_pkg;

	typedef enum logic [1:0] {
		K_FBYTE = 2'd0,
		K_FEND  = 2'd1,
		K_OK    = 2'd2,
		K_ERR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		LK_UNDEC  = 3'd0,
		LK_VERB   = 3'd1,
		LK_CAP    = 3'd2,
		LK_TASK   = 3'd3,
		LK_REASON = 3'd4,
		LK_TOKEN  = 3'd5,
		LK_IGNORE = 3'd6
	} line_kind_t;

	typedef enum logic [1:0] {
		REG_CAP    = 2'd0,
		REG_TASK   = 2'd1,
		REG_REASON = 2'd2,
		REG_TOKEN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  field_id;
		logic [7:0]  position;
		logic [7:0]  value_byte;
		logic [1:0]  verb_code;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [3:0]  line_offset;
		logic [4:0]  prefix_alive;
		line_kind_t  line_kind;
		logic        skipping;
		logic [7:0]  value_count;
		logic [2:0]  verb_alive;
		logic        verb_seen;
		logic [1:0]  verb_value;
		logic        finished;
	} hlp_state_t;

	// Up to two results per byte, slot 0 first.
	typedef struct packed {
		result_t [1:0] res;
		logic [1:0]    n;
	} step_out_t;

	typedef logic [3:0][7:0] lim_t;

	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [2:0] count;
		logic       room;
	} q_status_t;

	localparam hlp_state_t STATE_RESET = '{
		line_offset:  4'd0,
		prefix_alive: 5'h1F,
		line_kind:    LK_UNDEC,
		skipping:     1'b1,
		value_count:  8'd0,
		verb_alive:   3'h7,
		verb_seen:    1'b0,
		verb_value:   2'd0,
		finished:     1'b0
	};

	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [7:0] LIM_CAP_RST    = 8'd63;
	localparam logic [7:0] LIM_TASK_RST   = 8'd63;
	localparam logic [7:0] LIM_REASON_RST = 8'd127;
	localparam logic [7:0] LIM_TOKEN_RST  = 8'd8;

	localparam logic [7:0] PFX_TEXT [5][8] = '{
		'{"V", "E", "R", "B", " ", 8'h00, 8'h00, 8'h00},
		'{"C", "A", "P", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"T", "A", "S", "K", "-", "I", "D", " "},
		'{"R", "E", "A", "S", "O", "N", " ", 8'h00},
		'{"T", "O", "K", "E", "N", " ", 8'h00, 8'h00}
	};
	localparam logic [3:0] PFX_LEN [5] = '{4'd5, 4'd4, 4'd8, 4'd7, 4'd6};

	localparam logic [7:0] VERB_TEXT [3][8] = '{
		'{"r", "e", "q", "u", "e", "s", "t", 8'h00},
		'{"i", "s", "s", "u", "e", "d", 8'h00, 8'h00},
		'{"d", "e", "n", "i", "e", "d", 8'h00, 8'h00}
	};
	localparam logic [7:0] VERB_LEN [3] = '{8'd7, 8'd6, 8'd6};

	function automatic result_t mk_res(kind_t kind, logic [1:0] fid, logic [7:0] pos,
			logic [7:0] val, logic [1:0] verb);
		result_t r;
		r.kind        = kind;
		r.field_id    = fid;
		r.position    = pos;
		r.value_byte  = val;
		r.verb_code   = verb;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Message outcome: ok with the verb once one was accepted, error otherwise.
	function automatic result_t outcome_res(logic seen, logic [1:0] verb);
		if (seen) begin
			return mk_res(K_OK, 2'd0, 8'd0, 8'd0, verb);
		end
		return mk_res(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0);
	endfunction

endpackage

/* rtl/core/hlp_in_if.sv */
interface hlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source(output valid, output data_byte, output end_of_message, input ready);
	modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

/* rtl/core/hlp_out_if.sv */
interface hlp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] field_id;
	logic [7:0] position;
	logic [7:0] value_byte;
	logic [1:0] verb_code;
	logic       last_of_run;

	modport source(output valid, output kind, output field_id, output position,
		output value_byte, output verb_code, output last_of_run, input ready);
	modport sink(input valid, input kind, input field_id, input position,
		input value_byte, input verb_code, input last_of_run, output ready);
endinterface

/* rtl/core/header_line_parser.sv */
// Path: an accepted byte is held in the input register, processed by the step
// logic, and its results wait in the result queue for the output channel.
// Throughput: one byte per cycle while each byte yields at most one result and
// the result channel is ready; the single result port hands out one result at a
// time, and a four-entry result queue absorbs the difference.
// Reset: arst_n restarts the parser, empties the queue and restores default limits.
`include "assert_macros.svh"

module header_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	hlp_in_if.sink     msg,
	hlp_out_if.source  result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import hlp_pkg::*;

	// Field length limits; the user must write them only while the parser is idle, the block does not enforce it.
	lim_t limits_q;

	// Input register: one byte waiting for the parser step.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;

	// Parser state that carries from byte to byte within a message.
	hlp_state_t st_q;
	hlp_state_t st_next;
	step_out_t  step_out;

	result_t    head;
	q_status_t  q_stat;
	logic       fire;
	logic       accept;

	// The byte in the input register is processed as soon as the queue can
	// take the worst case of two results. The input register refills in the
	// same cycle, so bytes stream at full rate while the queue has room.
	assign fire      = valid_s1 && q_stat.room;
	assign msg.ready = !valid_s1 || fire;
	assign accept    = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q[REG_CAP]    <= LIM_CAP_RST;
			limits_q[REG_TASK]   <= LIM_TASK_RST;
			limits_q[REG_REASON] <= LIM_REASON_RST;
			limits_q[REG_TOKEN]  <= LIM_TOKEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAP:    limits_q[REG_CAP]    <= cfg_data;
				REG_TASK:   limits_q[REG_TASK]   <= cfg_data;
				REG_REASON: limits_q[REG_REASON] <= cfg_data;
				REG_TOKEN:  limits_q[REG_TOKEN]  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= msg.data_byte;
			eom_s1  <= msg.end_of_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (fire) begin
			st_q <= st_next;
		end
	end

	// Prefix matching, space skipping, verb check and field streaming all
	// happen in one short pass over the registered byte.
	hlp_step u_step (
		.st        (st_q),
		.data_byte (byte_s1),
		.eom       (eom_s1),
		.limits    (limits_q),
		.st_next   (st_next),
		.step_out  (step_out)
	);

	hlp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? step_out.n : 2'd0),
		.push_res  (step_out.res),
		.pop_ready (result.ready),
		.valid     (result.valid),
		.head      (head),
		.stat      (q_stat)
	);

	assign result.kind        = head.kind;
	assign result.field_id    = head.field_id;
	assign result.position    = head.position;
	assign result.value_byte  = head.value_byte;
	assign result.verb_code   = head.verb_code;
	assign result.last_of_run = head.last_of_run;

	// The last byte of a message always leaves the parser in its start state.
	`ASSERT_NEXT(a_eom_restart, clk, arst_n, fire && eom_s1, st_q == STATE_RESET)
	// Once a message is finished, bytes before its end produce no results.
	`ASSERT_IMPL(a_finished_quiet, clk, arst_n, fire && st_q.finished && !eom_s1, step_out.n == 2'd0)
	// The queue never holds more beats than it has entries.
	`ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, q_stat.count <= 3'(QDEPTH))
endmodule

/* rtl/core/hlp_step.sv */
// Per-byte parser update: next state and up to two results for one byte.
module hlp_step (
	input  hlp_pkg::hlp_state_t st,
	input  logic [7:0]          data_byte,
	input  logic                eom,
	input  hlp_pkg::lim_t       limits,
	output hlp_pkg::hlp_state_t st_next,
	output hlp_pkg::step_out_t  step_out
);
	import hlp_pkg::*;

	hlp_state_t nx;
	result_t    prim;
	result_t    tail;
	logic       prim_v;
	logic       tail_v;
	logic       hit_v;
	logic [1:0] hit_k;
	logic [1:0] fid;
	logic [7:0] lim;
	logic [7:0] kept;

	assign fid = 2'(3'(st.line_kind) - 3'(LK_CAP));
	assign lim = limits[fid];
	assign kept = (st.value_count < lim) ? st.value_count : lim;

	always_comb begin
		nx     = st;
		prim   = '0;
		tail   = '0;
		prim_v = 1'b0;
		tail_v = 1'b0;
		hit_v  = 1'b0;
		hit_k  = 2'd0;
		if (!st.finished) begin
			if (data_byte == CH_NL) begin
				if (st.line_kind == LK_UNDEC && st.line_offset == 4'd0) begin
					prim_v      = 1'b1;
					prim        = outcome_res(st.verb_seen, st.verb_value);
					nx.finished = 1'b1;
				end else if (st.line_kind == LK_VERB) begin
					for (int k = 0; k < 3; k++) begin
						if (st.verb_alive[k] && st.value_count == VERB_LEN[k]) begin
							hit_v = 1'b1;
							hit_k = 2'(k);
						end
					end
					if (hit_v) begin
						nx.verb_seen  = 1'b1;
						nx.verb_value = hit_k;
					end else begin
						prim_v      = 1'b1;
						prim        = mk_res(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0);
						nx.finished = 1'b1;
					end
				end else if (st.line_kind == LK_CAP || st.line_kind == LK_TASK ||
						st.line_kind == LK_REASON || st.line_kind == LK_TOKEN) begin
					prim_v = 1'b1;
					prim   = mk_res(K_FEND, fid, kept, 8'd0, 2'd0);
				end
				nx.line_offset  = 4'd0;
				nx.prefix_alive = 5'h1F;
				nx.line_kind    = LK_UNDEC;
				nx.skipping     = 1'b1;
				nx.value_count  = 8'd0;
				nx.verb_alive   = 3'h7;
				if (!nx.finished && eom) begin
					tail_v = 1'b1;
					tail   = outcome_res(nx.verb_seen, nx.verb_value);
				end
			end else begin
				if (st.line_kind == LK_UNDEC) begin
					for (int k = 0; k < 5; k++) begin
						if (st.prefix_alive[k]) begin
							if (st.line_offset < PFX_LEN[k] &&
									data_byte == PFX_TEXT[k][st.line_offset[2:0]]) begin
								if (st.line_offset + 4'd1 == PFX_LEN[k]) begin
									nx.line_kind = line_kind_t'(3'(k + 1));
								end
							end else begin
								nx.prefix_alive[k] = 1'b0;
							end
						end
					end
					if (nx.line_kind == LK_UNDEC && nx.prefix_alive == 5'd0) begin
						nx.line_kind = LK_IGNORE;
					end
					if (st.line_offset != 4'hF) begin
						nx.line_offset = st.line_offset + 4'd1;
					end
				end else if (st.line_kind != LK_IGNORE) begin
					if (!(st.skipping && data_byte == CH_SP)) begin
						nx.skipping = 1'b0;
						if (st.line_kind == LK_VERB) begin
							for (int k = 0; k < 3; k++) begin
								if (st.value_count >= VERB_LEN[k] ||
										data_byte != VERB_TEXT[k][st.value_count[2:0]]) begin
									nx.verb_alive[k] = 1'b0;
								end
							end
						end else if (st.value_count < lim) begin
							prim_v = 1'b1;
							prim   = mk_res(K_FBYTE, fid, st.value_count, data_byte, 2'd0);
						end
						if (st.value_count != 8'hFF) begin
							nx.value_count = st.value_count + 8'd1;
						end
					end
				end
				if (eom) begin
					tail_v = 1'b1;
					tail   = mk_res(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0);
				end
			end
		end
		if (eom) begin
			nx = STATE_RESET;
		end
	end

	always_comb begin
		step_out = '0;
		if (prim_v) begin
			step_out.res[0] = prim;
			step_out.res[1] = tail;
			step_out.n      = tail_v ? 2'd2 : 2'd1;
			step_out.res[0].last_of_run = !tail_v;
			step_out.res[1].last_of_run = tail_v;
		end else if (tail_v) begin
			step_out.res[0] = tail;
			step_out.res[0].last_of_run = 1'b1;
			step_out.n = 2'd1;
		end
	end

	assign st_next = nx;
endmodule

/* rtl/core/hlp_out_queue.sv */
// Small result queue: takes zero, one or two results a cycle, hands out one.
module hlp_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  hlp_pkg::result_t [1:0] push_res,
	input  logic                  pop_ready,
	output logic                  valid,
	output hlp_pkg::result_t      head,
	output hlp_pkg::q_status_t    stat
);
	import hlp_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	result_t            mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               pop;

	assign valid = (count_q != '0);
	assign pop   = valid && pop_ready;
	assign head  = mem_q[rd_ptr_q];

	assign stat.count = 3'(count_q);
	assign stat.room  = (count_q <= (PTR_W+1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_res[0];
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push_res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end
endmodule

/* tb/tb.sv */
module tb;
	import hlp_pkg::*;

	// One byte of a message on its way to the parser, with its end-of-message flag.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	hlp_in_if  msg_ch();
	hlp_out_if res_ch();

	header_line_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Header prefixes in the order of the line kinds that follow LK_UNDEC, and
	// the three verbs in the order of their codes.
	string hdr_prefix [5] = '{"VERB ", "CAP ", "TASK-ID ", "REASON ", "TOKEN "};
	string verb_word  [3] = '{"request", "issued", "denied"};

	// Per-field length limits as the parser holds them, indexed by field id.
	logic [7:0] keep_limit [4];

	// Our own copy of the parser state.
	logic [3:0] m_offset;
	logic [4:0] m_pfx_live;
	line_kind_t m_line;
	logic       m_skip;
	logic [7:0] m_count;
	logic [2:0] m_verb_live;
	logic       m_verb_seen;
	logic [1:0] m_verb;
	logic       m_done;

	msg_beat_t  bytes_to_send [$];  // bytes waiting for the input channel
	result_t    results_due [$];    // result beats the parser still owes us
	logic [7:0] draft [$];          // message under construction

	int src_idle_pct;
	int sink_stall_pct;
	int mismatches;

	function automatic void new_line();
		m_offset    = 4'd0;
		m_pfx_live  = 5'h1F;
		m_line      = LK_UNDEC;
		m_skip      = 1'b1;
		m_count     = 8'd0;
		m_verb_live = 3'h7;
	endfunction

	function automatic void new_message();
		new_line();
		m_verb_seen = 1'b0;
		m_verb      = 2'd0;
		m_done      = 1'b0;
	endfunction

	function automatic result_t make_beat(kind_t k, logic [1:0] fid, logic [7:0] pos,
			logic [7:0] val, logic [1:0] verb);
		result_t r;
		r.kind        = k;
		r.field_id    = fid;
		r.position    = pos;
		r.value_byte  = val;
		r.verb_code   = verb;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// The message verdict: ok carrying the verb if one was accepted, else error.
	function automatic result_t verdict();
		if (m_verb_seen)
			return make_beat(K_OK, 2'd0, 8'd0, 8'd0, m_verb);
		return make_beat(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0);
	endfunction

	// Advances our copy of the parser by one accepted byte and queues the result
	// beats that byte must produce, flagging the last of them.
	function automatic void parse_byte(logic [7:0] b, logic eom);
		result_t    out [$];
		result_t    r;
		int         hit;
		logic [1:0] fid;
		logic [7:0] lim;
		if (!m_done) begin
			if (b == CH_NL) begin
				if (m_line == LK_UNDEC && m_offset == 4'd0) begin
					// Blank line: the header is over.
					out.push_back(verdict());
					m_done = 1'b1;
				end else if (m_line == LK_VERB) begin
					hit = -1;
					for (int k = 0; k < 3; k++)
						if (m_verb_live[k] && int'(m_count) == verb_word[k].len())
							hit = k;
					if (hit >= 0) begin
						m_verb_seen = 1'b1;
						m_verb      = 2'(hit);
					end else begin
						out.push_back(make_beat(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0));
						m_done = 1'b1;
					end
				end else if (m_line != LK_UNDEC && m_line != LK_IGNORE) begin
					fid = 2'(m_line - LK_CAP);
					lim = keep_limit[fid];
					out.push_back(make_beat(K_FEND, fid, (m_count < lim) ? m_count : lim,
						8'd0, 2'd0));
				end
				new_line();
				// A message that ends right on a newline still gets its verdict.
				if (!m_done && eom)
					out.push_back(verdict());
			end else begin
				if (m_line == LK_UNDEC) begin
					// Still matching the prefix; every candidate is tracked at once.
					for (int k = 0; k < 5; k++) begin
						if (m_pfx_live[k]) begin
							if (int'(m_offset) < hdr_prefix[k].len() &&
									b == hdr_prefix[k][m_offset]) begin
								if (int'(m_offset) + 1 == hdr_prefix[k].len())
									m_line = line_kind_t'(k + 1);
							end else begin
								m_pfx_live[k] = 1'b0;
							end
						end
					end
					if (m_line == LK_UNDEC && m_pfx_live == 5'd0)
						m_line = LK_IGNORE;
					if (m_offset < 4'd15)
						m_offset = m_offset + 4'd1;
				end else if (m_line != LK_IGNORE) begin
					if (!(m_skip && b == CH_SP)) begin
						m_skip = 1'b0;
						if (m_line == LK_VERB) begin
							for (int k = 0; k < 3; k++)
								if (int'(m_count) >= verb_word[k].len() ||
										b != verb_word[k][m_count])
									m_verb_live[k] = 1'b0;
						end else begin
							fid = 2'(m_line - LK_CAP);
							if (m_count < keep_limit[fid])
								out.push_back(make_beat(K_FBYTE, fid, m_count, b, 2'd0));
						end
						if (m_count != 8'd255)
							m_count = m_count + 8'd1;
					end
				end
				// The message ended inside a line that never got its newline.
				if (eom)
					out.push_back(make_beat(K_ERR, 2'd0, 8'd0, 8'd0, 2'd0));
			end
		end
		if (eom)
			new_message();
		foreach (out[i]) begin
			r = out[i];
			r.last_of_run = (i == out.size() - 1);
			results_due.push_back(r);
		end
	endfunction

	function automatic string beat_text(result_t r);
		return $sformatf("kind=%0d field=%0d pos=%0d byte=%02h verb=%0d last=%0d",
			r.kind, r.field_id, r.position, r.value_byte, r.verb_code, r.last_of_run);
	endfunction

	// ------------------------------------------------------------------
	// Message construction
	// ------------------------------------------------------------------

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endfunction

	function automatic logic [7:0] any_but_newline();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == CH_NL)
			v = 8'($urandom_range(11, 255));
		return v;
	endfunction

	function automatic void add_value(int n, bit with_spaces);
		for (int i = 0; i < n; i++)
			if (with_spaces && $urandom_range(0, 5) == 0)
				draft.push_back(CH_SP);
			else
				draft.push_back(any_but_newline());
	endfunction

	function automatic void add_spaces();
		repeat ($urandom_range(0, 2))
			draft.push_back(CH_SP);
	endfunction

	// One newline-terminated line: mostly header lines, with good and bad verbs,
	// field lines of varied length, junk and truncated prefixes mixed in.
	function automatic void add_header_line();
		int    pick;
		int    n;
		string v;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			add_text("VERB ");
			add_spaces();
			add_text(verb_word[$urandom_range(0, 2)]);
		end else if (pick < 28) begin
			// A verb that is close to a good one but not quite.
			add_text("VERB ");
			add_spaces();
			v = verb_word[$urandom_range(0, 2)];
			case ($urandom_range(0, 3))
				0: add_text(v.substr(0, v.len() - 2));
				1: begin
					add_text(v);
					draft.push_back(any_but_newline());
				end
				2: begin
					add_text(v);
					add_text(" ");
				end
				default: add_value($urandom_range(0, 8), 1'b1);
			endcase
		end else if (pick < 80) begin
			add_text(hdr_prefix[$urandom_range(1, 4)]);
			add_spaces();
			// Rarely a value long enough to saturate the byte counter.
			if ($urandom_range(0, 199) == 0)
				n = $urandom_range(256, 300);
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(13, 70);
			else
				n = $urandom_range(0, 12);
			add_value(n, $urandom_range(0, 3) == 0);
		end else if (pick < 90) begin
			add_value($urandom_range(1, 20), 1'b1);
		end else begin
			v = hdr_prefix[$urandom_range(0, 4)];
			add_text(v.substr(0, $urandom_range(0, v.len() - 2)));
			if ($urandom_range(0, 1) == 0)
				add_value($urandom_range(1, 6), 1'b0);
		end
		draft.push_back(CH_NL);
	endfunction

	// Moves the draft onto the send queue, flagging its last byte.
	function automatic void queue_message();
		msg_beat_t mb;
		foreach (draft[i]) begin
			mb.data = draft[i];
			mb.last = (i == draft.size() - 1);
			bytes_to_send.push_back(mb);
		end
		draft.delete();
	endfunction

	function automatic void compose_message();
		int ending;
		if ($urandom_range(0, 14) == 0) begin
			// Raw noise, newlines included.
			repeat ($urandom_range(1, 10))
				draft.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 6))
			add_header_line();
		ending = $urandom_range(0, 9);
		if (ending < 5) begin
			// Blank line, then a few bytes the parser has to ignore.
			draft.push_back(CH_NL);
			repeat ($urandom_range(0, 3))
				draft.push_back(8'($urandom_range(0, 255)));
		end else if (ending < 8) begin
			if (draft.size() == 0)
				draft.push_back(CH_NL);
		end else begin
			add_value($urandom_range(1, 8), 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------
	// Input channel driver: offers the head of the send queue, keeps it steady
	// until the beat is taken, and updates our parser copy on acceptance.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		logic offer;
		if (!arst_n) begin
			msg_ch.valid          <= 1'b0;
			msg_ch.data_byte      <= 8'd0;
			msg_ch.end_of_message <= 1'b0;
		end else begin
			offer = msg_ch.valid;
			if (msg_ch.valid && msg_ch.ready) begin
				parse_byte(bytes_to_send[0].data, bytes_to_send[0].last);
				void'(bytes_to_send.pop_front());
				offer = 1'b0;
			end
			if (!offer && bytes_to_send.size() != 0 &&
					$urandom_range(0, 99) >= src_idle_pct)
				offer = 1'b1;
			msg_ch.valid <= offer;
			if (offer) begin
				msg_ch.data_byte      <= bytes_to_send[0].data;
				msg_ch.end_of_message <= bytes_to_send[0].last;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result channel monitor: every accepted beat is checked against the oldest
	// beat we still owe, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.kind        = kind_t'(res_ch.kind);
				got.field_id    = res_ch.field_id;
				got.position    = res_ch.position;
				got.value_byte  = res_ch.value_byte;
				got.verb_code   = res_ch.verb_code;
				got.last_of_run = res_ch.last_of_run;
				if (results_due.size() == 0) begin
					$display("%0t: result beat with none expected: expected nothing, got %s",
						$time, beat_text(got));
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (got.kind !== want.kind || got.field_id !== want.field_id ||
							got.position !== want.position ||
							got.value_byte !== want.value_byte ||
							got.verb_code !== want.verb_code ||
							got.last_of_run !== want.last_of_run) begin
						$display("%0t: result mismatch: expected %s, got %s",
							$time, beat_text(want), beat_text(got));
						mismatches++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Waits until the sender has nothing left and every owed beat has come back.
	task automatic wait_quiet();
		while (bytes_to_send.size() != 0 || results_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes all four limits, one register per clock, while the parser is idle.
	task automatic apply_limits(input logic [7:0] cap_l, input logic [7:0] task_l,
			input logic [7:0] reason_l, input logic [7:0] token_l);
		keep_limit[REG_CAP]    = cap_l;
		keep_limit[REG_TASK]   = task_l;
		keep_limit[REG_REASON] = reason_l;
		keep_limit[REG_TOKEN]  = token_l;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CAP;
		cfg_data  <= cap_l;
		@(posedge clk);
		cfg_index <= REG_TASK;
		cfg_data  <= task_l;
		@(posedge clk);
		cfg_index <= REG_REASON;
		cfg_data  <= reason_l;
		@(posedge clk);
		cfg_index <= REG_TOKEN;
		cfg_data  <= token_l;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_limit();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 12));
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int sent;
		// Every input is known from time zero, with reset asserted from the start.
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = 8'd0;
		msg_ch.end_of_message = 1'b0;
		res_ch.ready          = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_CAP;
		cfg_data              = 8'd0;
		arst_n                = 1'b0;
		keep_limit[REG_CAP]    = LIM_CAP_RST;
		keep_limit[REG_TASK]   = LIM_TASK_RST;
		keep_limit[REG_REASON] = LIM_REASON_RST;
		keep_limit[REG_TOKEN]  = LIM_TOKEN_RST;
		new_message();
		mismatches     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed messages under the reset limits.
		// A lone newline is a blank line with no verb, so the message fails.
		draft.push_back(CH_NL);
		queue_message();
		// A single 0xFF that ends the message is an unterminated line.
		draft.push_back(8'hFF);
		queue_message();
		// A bad verb fails the message; the byte after it is ignored.
		add_text("VERB x\nQ");
		queue_message();
		// Accepted verb, then a token with the extreme byte values. The message
		// ends on the token's newline: field end first, then the ok verdict.
		add_text("VERB  issued\nTOKEN ");
		draft.push_back(8'h00);
		draft.push_back(8'hFF);
		draft.push_back(CH_NL);
		queue_message();

		// Random phases. Each phase starts from an idle parser with new limits
		// and its own idling pattern; the limits go through both extremes.
		for (int phase = 0; phase < 10; phase++) begin
			wait_quiet();
			// A byte that produces nothing may still be inside the parser.
			repeat (8) @(posedge clk);
			case (phase)
				0: apply_limits(8'd0, 8'd0, 8'd0, 8'd0);
				1: apply_limits(8'd255, 8'd255, 8'd255, 8'd255);
				2: apply_limits(8'd1, 8'd2, 8'd3, 8'd4);
				default: apply_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
			endcase
			case (phase % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 83;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 83;
				end
				default: begin
					src_idle_pct   = 13;
					sink_stall_pct = 13;
				end
			endcase
			sent = 0;
			while (sent < 175) begin
				compose_message();
				sent += draft.size();
				// Now and then the sender holds off until the parser has drained.
				if ($urandom_range(0, 19) == 0)
					wait_quiet();
				queue_message();
			end
		end

		wait_quiet();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("PASS header_line_parser");
		end else begin
			$display("FAIL header_line_parser");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("FAIL header_line_parser");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/hlp_pkg.sv
rtl/core/hlp_in_if.sv
rtl/core/hlp_out_if.sv
rtl/core/hlp_step.sv
rtl/core/hlp_out_queue.sv
rtl/core/header_line_parser.sv
tb/tb.sv
